// File: design/xtnl_pkg.sv
// shared types and constants for the xor trie lookup block
package xtnl_pkg;

   localparam int KEY_BITS    = 30;
   localparam int NODE_POOL   = 65536;
   localparam int ID_BITS     = 16;
   localparam int NODE_BITS   = $clog2(NODE_POOL);
   localparam int NEED_BITS   = NODE_BITS + 1;
   localparam int LEVEL_BITS  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int ACT_BITS    = 2;
   localparam int STATUS_BITS = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // highest node index the pool can hand out
   localparam logic [NEED_BITS-1:0] POOL_LAST = NEED_BITS'(NODE_POOL - 1);

   // request action codes
   localparam logic [ACT_BITS-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_BITS-1:0] ACT_QMAX   = 2'd1;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_QMAX,
      OP_QMIN
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_INSERTED = 2'd0,
      ST_HIT      = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_WALK,
      ENG_BUILD,
      ENG_FINISH
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]  id;
   } item_type;

   typedef logic [1:0][NODE_BITS-1:0] row_type;

endpackage

// File: design/xtnl_front.sv
// front stage: takes request transfers and classifies the action
module xtnl_front
   import xtnl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACT_BITS-1:0] req_action,
   input  logic [KEY_BITS-1:0] req_key_value,
   input  logic [ID_BITS-1:0]  req_item_id,
   output logic                push_valid,
   output item_type            push_item,
   input  logic                push_ready
);

   logic     hold_valid_ff, hold_valid_in;
   item_type hold_item_ff, hold_item_in;
   logic     accept;
   op_type   op_class;

   assign req_stall  = hold_valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

   always_comb begin
      case (req_action)
         ACT_INSERT: op_class = OP_INSERT;
         ACT_QMAX:   op_class = OP_QMAX;
         default:    op_class = OP_QMIN;   // unused code behaves as min query
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff && !push_ready;
      hold_item_in  = hold_item_ff;
      if (accept) begin
         hold_valid_in   = 1'b1;
         hold_item_in.op = op_class;
         hold_item_in.key = req_key_value;
         hold_item_in.id  = req_item_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_item_ff <= hold_item_in;
   end

endmodule

// File: design/xtnl_queue.sv
// small fifo between the front stage and the walk engine
module xtnl_queue
   import xtnl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  item_type             push_item,
   output logic                 push_ready,
   output logic                 pop_valid,
   output item_type             pop_item,
   input  logic                 pop_ready,
   output logic [QCNT_BITS-1:0] count
);

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/xtnl_engine.sv
// back end: trie walk, node allocation, leaf id store and result register
module xtnl_engine
   import xtnl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  item_type           pop_item,
   output logic               pop_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ID_BITS-1:0] rsp_found_id,
   output status_type         rsp_status
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic [NODE_BITS-1:0]  nodes_used_ff, nodes_used_in;
   logic                  holds_keys_ff, holds_keys_in;
   logic                  is_hit_ff, is_hit_in;
   row_type               root_ff, root_in;
   row_type               rd_row_ff;
   logic [ID_BITS-1:0]    leaf_rd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]    rsp_found_ff, rsp_found_in;
   status_type            rsp_status_ff, rsp_status_in;

   row_type               child_mem [NODE_POOL];
   logic [ID_BITS-1:0]    leaf_mem  [NODE_POOL];

   logic                  mem_we;
   logic [NODE_BITS-1:0]  mem_waddr;
   row_type               mem_wdata;
   logic                  leaf_we;
   logic [NODE_BITS-1:0]  rd_addr;
   logic [NODE_BITS-1:0]  leaf_addr;

   row_type               cur_row;
   logic                  key_bit, pref;
   logic [NODE_BITS-1:0]  ins_next, q_next, new_node;
   logic [NEED_BITS-1:0]  need;
   logic                  pool_ok, slot_free, is_insert, last_level;

   // node 0 (root) lives in flops, every other row is read from memory
   assign cur_row    = (node_ff == '0) ? root_ff : rd_row_ff;
   assign key_bit    = key_ff[level_ff];
   assign is_insert  = (op_ff == OP_INSERT);
   assign pref       = key_bit ^ (op_ff == OP_QMAX);
   assign ins_next   = cur_row[key_bit];
   assign q_next     = (cur_row[pref] != '0) ? cur_row[pref] : cur_row[~pref];
   assign new_node   = nodes_used_ff + 1'b1;
   assign need       = {1'b0, nodes_used_ff} + NEED_BITS'(level_ff) + 1'b1;
   assign pool_ok    = (need <= POOL_LAST);
   assign last_level = (level_ff == '0);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign pop_ready  = (state_ff == ENG_IDLE) && slot_free;
   assign rd_addr    = is_insert ? ins_next : q_next;
   assign leaf_addr  = (q_next == '0) ? node_ff : q_next;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found_id = rsp_found_ff;
   assign rsp_status   = rsp_status_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (pop_valid && pop_ready) begin
               state_in = ENG_WALK;
            end
         end
         ENG_WALK: begin
            if (is_insert) begin
               if (ins_next == '0) begin
                  if (!pool_ok) begin
                     state_in = ENG_IDLE;
                  end else if (last_level) begin
                     state_in = ENG_FINISH;
                  end else begin
                     state_in = ENG_BUILD;
                  end
               end else if (last_level) begin
                  state_in = ENG_FINISH;
               end
            end else begin
               if (!holds_keys_ff) begin
                  state_in = ENG_IDLE;
               end else if (q_next == '0 || last_level) begin
                  state_in = ENG_FINISH;
               end
            end
         end
         ENG_BUILD: begin
            if (last_level) begin
               state_in = ENG_FINISH;
            end
         end
         ENG_FINISH: begin
            state_in = ENG_IDLE;
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      id_in         = id_ff;
      level_in      = level_ff;
      node_in       = node_ff;
      nodes_used_in = nodes_used_ff;
      holds_keys_in = holds_keys_ff;
      is_hit_in     = is_hit_ff;
      root_in       = root_ff;
      mem_we        = 1'b0;
      mem_waddr     = node_ff;
      mem_wdata     = cur_row;
      leaf_we       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (pop_valid && pop_ready) begin
               op_in    = pop_item.op;
               key_in   = pop_item.key;
               id_in    = pop_item.id;
               level_in = LEVEL_BITS'(KEY_BITS - 1);
               node_in  = '0;
            end
         end
         ENG_WALK: begin
            level_in = level_ff - 1'b1;
            if (is_insert) begin
               is_hit_in = 1'b0;
               if (ins_next == '0) begin
                  if (pool_ok) begin
                     // link first new node into the existing parent
                     if (node_ff == '0) begin
                        root_in[key_bit] = new_node;
                     end else begin
                        mem_we             = 1'b1;
                        mem_wdata[key_bit] = new_node;
                     end
                     nodes_used_in = new_node;
                     node_in       = new_node;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_found_in  = '0;
                     rsp_status_in = ST_FULL;
                  end
               end else begin
                  node_in = ins_next;
               end
            end else begin
               is_hit_in = 1'b1;
               node_in   = q_next;
               if (!holds_keys_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_found_in  = '0;
                  rsp_status_in = ST_EMPTY;
               end
            end
         end
         ENG_BUILD: begin
            // fresh node: one child toward the key, the other empty
            mem_we             = 1'b1;
            mem_wdata          = '0;
            mem_wdata[key_bit] = new_node;
            nodes_used_in      = new_node;
            node_in            = new_node;
            level_in           = level_ff - 1'b1;
         end
         ENG_FINISH: begin
            rsp_valid_in = 1'b1;
            if (is_hit_ff) begin
               rsp_found_in  = leaf_rd_ff;
               rsp_status_in = ST_HIT;
            end else begin
               leaf_we       = 1'b1;
               holds_keys_in = 1'b1;
               rsp_found_in  = '0;
               rsp_status_in = ST_INSERTED;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ENG_IDLE;
         nodes_used_ff <= '0;
         holds_keys_ff <= 1'b0;
         root_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         holds_keys_ff <= holds_keys_in;
         root_ff       <= root_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      id_ff         <= id_in;
      level_ff      <= level_in;
      node_ff       <= node_in;
      is_hit_ff     <= is_hit_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         child_mem[mem_waddr] <= mem_wdata;
      end
      rd_row_ff <= child_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[node_ff] <= id_ff;
      end
      leaf_rd_ff <= leaf_mem[leaf_addr];
   end

endmodule

// File: design/xor_trie_nearest_lookup.sv
// top level of the xor trie lookup: front stage, queue and walk engine
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_action, req_key_value, req_item_id
//   rsp_      out        rsp_valid/rsp_stall  rsp_found_id, rsp_status
//
// the engine handles an item as a pop, a step at each key level (a dependent
// child-link read, or one new node row written) and a result step; an empty-trie
// query ends after its first walk step; a pool-full insert stops at its first missing link
// reset is synchronous; node rows are written when allocated, so no clearing pass
// the front and queue keep taking transfers while the engine walks or a result stalls,
// until they fill; the engine starts a new item only once the result register is free
module xor_trie_nearest_lookup
   import xtnl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ACT_BITS-1:0]    req_action,
   input  logic [KEY_BITS-1:0]    req_key_value,
   input  logic [ID_BITS-1:0]     req_item_id,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ID_BITS-1:0]     rsp_found_id,
   output logic [STATUS_BITS-1:0] rsp_status
);

   // front to queue
   logic     push_valid, push_ready;
   item_type push_item;

   // queue to engine
   logic     pop_valid, pop_ready;
   item_type pop_item;
   logic [QCNT_BITS-1:0] q_count;

   status_type rsp_status_e;

   xtnl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_key_value (req_key_value),
      .req_item_id   (req_item_id),
      .push_valid    (push_valid),
      .push_item     (push_item),
      .push_ready    (push_ready)
   );

   xtnl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .count      (q_count)
   );

   xtnl_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_item     (pop_item),
      .pop_ready    (pop_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_found_id (rsp_found_id),
      .rsp_status   (rsp_status_e)
   );

   assign rsp_status = rsp_status_e;

   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   // only a query hit carries an id
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status_e != ST_HIT) |-> rsp_found_id == '0)
      else $error("nonzero id on a non-hit result");

   // engine takes a new item only when the result register is free
   a_pop_slot: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |-> !rsp_valid || !rsp_stall)
      else $error("item started while a result is stalled");

   // a full queue forces the front to stall once it holds an item
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      push_valid && (q_count == QCNT_BITS'(QUEUE_DEPTH)) |-> req_stall)
      else $error("request taken while the queue is full");

endmodule
